FILE: rtl/rmhp_pkg.sv
`default_nettype none

package rmhp_pkg;

    // Width of the reported payload length field.
    localparam int PAYLOAD_LEN_W = 16;

    // Default number of bits for the payload counter before saturation.
    localparam int LENGTH_BITS_DEFAULT = 16;

    // A varint id is at most this many bytes long.
    localparam logic [3:0] ID_MAX_BYTES = 4'd10;

    // Message type codes from bits 3:1 of the flag byte.
    localparam logic [2:0] MT_REQUEST  = 3'd0;
    localparam logic [2:0] MT_NOTIFY   = 3'd1;
    localparam logic [2:0] MT_RESPONSE = 3'd2;
    localparam logic [2:0] MT_PUSH     = 3'd3;

    // Last code byte index of the 4-byte response code.
    localparam logic [1:0] CODE_LAST_BYTE = 2'd3;

    // Parse phase. The encoding doubles as the byte role reported for each item.
    typedef enum logic [2:0] {
        PH_FLAG    = 3'd0,
        PH_ID      = 3'd1,
        PH_RLEN    = 3'd2,
        PH_ROUTE   = 3'd3,
        PH_CODE    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_ERROR   = 3'd6
    } phase_t;

    // One input item: a message byte and its end marker.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // One result item: role of the byte plus the message summary.
    typedef struct packed {
        logic [2:0]               byte_role;
        logic [7:0]               byte_value;
        logic                     is_last;
        logic                     status;
        logic [2:0]               msg_type;
        logic [2:0]               data_kind;
        logic [63:0]              msg_id;
        logic signed [31:0]       resp_code;
        logic [7:0]               route_len;
        logic [PAYLOAD_LEN_W-1:0] payload_len;
    } out_item_t;

    // Header parse state carried from byte to byte.
    typedef struct packed {
        phase_t      phase;
        logic [2:0]  msg_type;
        logic [2:0]  data_kind;
        logic [63:0] id_accum;
        logic [3:0]  id_count;
        logic [7:0]  route_total;
        logic [7:0]  route_left;
        logic [31:0] code_accum;
        logic [1:0]  code_count;
    } parse_state_t;

endpackage

`default_nettype wire

FILE: rtl/rmhp_step.sv
`default_nettype none

// Per-byte parse step: from the current state and one byte, computes the
// next state, the payload count and the result item.
module rmhp_step #(
    parameter int CNT_W = rmhp_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire rmhp_pkg::parse_state_t state,
    input  wire logic [CNT_W-1:0]       pcount,
    input  wire rmhp_pkg::in_item_t     item,
    output rmhp_pkg::parse_state_t      state_next,
    output logic [CNT_W-1:0]            pcount_next,
    output rmhp_pkg::out_item_t         result
);

    logic [7:0]             b;
    logic                   last;
    logic [2:0]             flag_type;
    logic [3:0]             id_count_inc;
    logic [7:0]             route_dec;
    logic                   bad;
    rmhp_pkg::phase_t       phase_next;
    rmhp_pkg::parse_state_t work;
    logic [CNT_W-1:0]       pcount_work;
    logic [63:0]            id_add;
    logic [31:0]            code_add;
    logic                   status;
    logic                   has_id;

    assign b            = item.data_byte;
    assign last         = item.last_byte;
    assign flag_type    = b[3:1];
    assign id_count_inc = state.id_count + 4'd1;
    assign route_dec    = state.route_left - 8'd1;

    // Next phase and error detection.
    always_comb
    begin
        phase_next = state.phase;
        bad        = 1'b0;
        unique case (state.phase)
            rmhp_pkg::PH_FLAG:
            begin
                if (flag_type[2])
                    bad = 1'b1;
                else if (flag_type == rmhp_pkg::MT_REQUEST ||
                         flag_type == rmhp_pkg::MT_RESPONSE)
                    phase_next = rmhp_pkg::PH_ID;
                else
                    phase_next = rmhp_pkg::PH_RLEN;
                if (last)
                    bad = 1'b1;
            end
            rmhp_pkg::PH_ID:
            begin
                if (!b[7])
                    phase_next = (state.msg_type == rmhp_pkg::MT_REQUEST) ?
                                 rmhp_pkg::PH_RLEN : rmhp_pkg::PH_CODE;
                else if (id_count_inc >= rmhp_pkg::ID_MAX_BYTES)
                    bad = 1'b1;
                if (last)
                    bad = 1'b1;
            end
            rmhp_pkg::PH_RLEN:
            begin
                phase_next = (b != 8'd0) ? rmhp_pkg::PH_ROUTE : rmhp_pkg::PH_PAYLOAD;
                if (last && b != 8'd0)
                    bad = 1'b1;
            end
            rmhp_pkg::PH_ROUTE:
            begin
                if (route_dec == 8'd0)
                    phase_next = rmhp_pkg::PH_PAYLOAD;
                else if (last)
                    bad = 1'b1;
            end
            rmhp_pkg::PH_CODE:
            begin
                if (state.code_count == rmhp_pkg::CODE_LAST_BYTE)
                    phase_next = rmhp_pkg::PH_PAYLOAD;
                else if (last)
                    bad = 1'b1;
            end
            default:
            begin
                phase_next = state.phase;
            end
        endcase
        if (bad)
            phase_next = rmhp_pkg::PH_ERROR;
    end

    // Id group placed at its 7-bit position; only ten positions exist.
    always_comb
    begin
        id_add = '0;
        for (int i = 0; i < 10; i++)
        begin
            if (state.id_count == 4'(i))
                id_add = 64'(b[6:0]) << (7 * i);
        end
    end

    // Code byte placed at its little-endian position.
    always_comb
    begin
        code_add = '0;
        case (state.code_count)
            2'd0:    code_add = {24'd0, b};
            2'd1:    code_add = {16'd0, b, 8'd0};
            2'd2:    code_add = {8'd0, b, 16'd0};
            default: code_add = {b, 24'd0};
        endcase
    end

    // Field accumulation for the current phase.
    always_comb
    begin
        work        = state;
        pcount_work = pcount;
        case (state.phase)
            rmhp_pkg::PH_FLAG:
            begin
                work           = '0;
                pcount_work    = '0;
                work.msg_type  = flag_type;
                work.data_kind = b[6:4];
            end
            rmhp_pkg::PH_ID:
            begin
                work.id_accum = state.id_accum | id_add;
                work.id_count = id_count_inc;
            end
            rmhp_pkg::PH_RLEN:
            begin
                work.route_total = b;
                work.route_left  = b;
            end
            rmhp_pkg::PH_ROUTE:
            begin
                work.route_left = route_dec;
            end
            rmhp_pkg::PH_CODE:
            begin
                work.code_accum = state.code_accum | code_add;
                if (state.code_count != rmhp_pkg::CODE_LAST_BYTE)
                    work.code_count = state.code_count + 2'd1;
            end
            rmhp_pkg::PH_PAYLOAD:
            begin
                if (pcount != '1)
                    pcount_work = pcount + 1'b1;
            end
            default:
            begin
                work = state;
            end
        endcase
        work.phase = phase_next;
    end

    // Result item and end-of-message clear.
    always_comb
    begin
        status = bad || (state.phase == rmhp_pkg::PH_ERROR);
        has_id = (work.msg_type == rmhp_pkg::MT_REQUEST) ||
                 (work.msg_type == rmhp_pkg::MT_RESPONSE);

        result            = '0;
        result.byte_role  = 3'(state.phase);
        result.byte_value = b;
        if (last)
        begin
            result.is_last   = 1'b1;
            result.status    = status;
            result.msg_type  = work.msg_type;
            result.data_kind = work.data_kind;
            if (!status)
            begin
                if (has_id)
                    result.msg_id = work.id_accum;
                if (work.msg_type == rmhp_pkg::MT_RESPONSE)
                    result.resp_code = work.code_accum;
                else
                    result.route_len = work.route_total;
                result.payload_len = rmhp_pkg::PAYLOAD_LEN_W'(pcount_work);
            end
        end

        if (last)
        begin
            state_next  = '0;
            pcount_next = '0;
        end
        else
        begin
            state_next  = work;
            pcount_next = pcount_work;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rpc_message_header_parser_top.sv
`default_nettype none

// RPC message header parser.
// Message bytes enter on the byte channel (byte_valid / byte_ready, payload
// byte_item), one byte per item, with last_byte marking the end of a message.
// For every byte one result item leaves on the result channel (result_valid /
// result_ready, payload result_item) carrying the role of that byte; the item
// for the last byte also carries status, type, data kind, id, response code,
// route length and payload length.
// The path has two registers, an input register and then the parse step into
// the result register. Throughput is one byte per cycle while the receiver
// does not stall; the parse state loop has a single register.
// When the receiver stalls, the result register holds and the input register
// fills, after which byte_ready drops until the result is taken.
// Reset clears both registers' valid flags and returns the parser to
// expecting a flag byte. The payload counter saturates at 2^LENGTH_BITS - 1,
// capped at 65535.
module rpc_message_header_parser_top #(
    parameter int LENGTH_BITS = rmhp_pkg::LENGTH_BITS_DEFAULT
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     byte_valid,
    output logic                    byte_ready,
    input  wire rmhp_pkg::in_item_t byte_item,
    output logic                    result_valid,
    input  wire                     result_ready,
    output rmhp_pkg::out_item_t     result_item
);

    localparam int CNT_W = (LENGTH_BITS < rmhp_pkg::PAYLOAD_LEN_W) ?
                           LENGTH_BITS : rmhp_pkg::PAYLOAD_LEN_W;

    logic                   in_valid_reg;
    rmhp_pkg::in_item_t     in_item_reg;
    rmhp_pkg::parse_state_t state_reg;
    rmhp_pkg::parse_state_t state_next;
    logic [CNT_W-1:0]       pcount_reg;
    logic [CNT_W-1:0]       pcount_next;
    logic                   out_valid_reg;
    rmhp_pkg::out_item_t    out_item_reg;
    rmhp_pkg::out_item_t    step_result;
    logic                   advance;

    // The buffered item moves on when the result register is free or emptying.
    assign advance      = in_valid_reg && (!out_valid_reg || result_ready);
    assign byte_ready   = !in_valid_reg || advance;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

    rmhp_step #(
        .CNT_W (CNT_W)
    ) u_step (
        .state       (state_reg),
        .pcount      (pcount_reg),
        .item        (in_item_reg),
        .state_next  (state_next),
        .pcount_next (pcount_next),
        .result      (step_result)
    );

    // Input register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (byte_ready)
            in_valid_reg <= byte_valid;
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
            in_item_reg <= byte_item;
    end

    // Parse state advances once per item processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            pcount_reg <= '0;
        end
        else if (advance)
        begin
            state_reg  <= state_next;
            pcount_reg <= pcount_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (result_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= step_result;
    end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int LENGTH_BITS = rmhp_pkg::LENGTH_BITS_DEFAULT;
    localparam logic [15:0] PAYLOAD_CAP =
        (LENGTH_BITS >= 16) ? 16'hffff : 16'((1 << LENGTH_BITS) - 1);
    localparam int RANDOM_BYTES = 1580;
    localparam int LONG_PAYLOAD_BYTES = 300;

    // Shapes of the messages built for random traffic.
    typedef enum int {
        MSG_GOOD,
        MSG_TRUNCATED,
        MSG_LONG_ID,
        MSG_BAD_TYPE,
        MSG_NOISE
    } msg_shape_t;

    logic                clk;
    logic                rst_n = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_ready;
    rmhp_pkg::in_item_t  byte_item = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    rmhp_pkg::out_item_t result_item;

    // Predicted header parse state.
    rmhp_pkg::phase_t st_phase;
    logic [2:0]       st_type;
    logic [2:0]       st_kind;
    logic [63:0]      st_id;
    logic [3:0]       st_id_cnt;
    logic [7:0]       st_route_total;
    logic [7:0]       st_route_left;
    logic [31:0]      st_code;
    logic [1:0]       st_code_cnt;
    logic [15:0]      st_payload_cnt;
    logic             st_error;

    rmhp_pkg::out_item_t expected_results[$];
    logic [7:0]          msg_bytes[$];
    bit                  full_rate = 1'b0;
    int                  fail_count = 0;

    rpc_message_header_parser_top #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Return the parser to expecting a flag byte.
    function automatic void clear_parse_state();
        st_phase       = rmhp_pkg::PH_FLAG;
        st_type        = '0;
        st_kind        = '0;
        st_id          = '0;
        st_id_cnt      = '0;
        st_route_total = '0;
        st_route_left  = '0;
        st_code        = '0;
        st_code_cnt    = '0;
        st_payload_cnt = '0;
        st_error       = 1'b0;
    endfunction

    // Advance the predicted parser by one byte and return the result it reports.
    function automatic rmhp_pkg::out_item_t parse_byte(rmhp_pkg::in_item_t it);
        rmhp_pkg::out_item_t r;
        rmhp_pkg::phase_t    role;
        logic                bad;
        logic [7:0]          b;
        b    = it.data_byte;
        role = st_phase;
        bad  = 1'b0;
        case (st_phase)
            rmhp_pkg::PH_FLAG:
            begin
                clear_parse_state();
                st_type = b[3:1];
                st_kind = b[6:4];
                if (st_type > rmhp_pkg::MT_PUSH)
                    bad = 1'b1;
                else if (st_type == rmhp_pkg::MT_REQUEST ||
                         st_type == rmhp_pkg::MT_RESPONSE)
                    st_phase = rmhp_pkg::PH_ID;
                else
                    st_phase = rmhp_pkg::PH_RLEN;
                if (it.last_byte)
                    bad = 1'b1;
            end
            rmhp_pkg::PH_ID:
            begin
                if (st_id_cnt < rmhp_pkg::ID_MAX_BYTES)
                    st_id = st_id | (64'(b[6:0]) << (7 * st_id_cnt));
                st_id_cnt = st_id_cnt + 4'd1;
                if (!b[7])
                    st_phase = (st_type == rmhp_pkg::MT_REQUEST) ?
                               rmhp_pkg::PH_RLEN : rmhp_pkg::PH_CODE;
                else if (st_id_cnt >= rmhp_pkg::ID_MAX_BYTES)
                    bad = 1'b1;
                if (it.last_byte)
                    bad = 1'b1;
            end
            rmhp_pkg::PH_RLEN:
            begin
                st_route_total = b;
                st_route_left  = b;
                st_phase = (b != 8'd0) ? rmhp_pkg::PH_ROUTE : rmhp_pkg::PH_PAYLOAD;
                if (it.last_byte && b != 8'd0)
                    bad = 1'b1;
            end
            rmhp_pkg::PH_ROUTE:
            begin
                st_route_left = st_route_left - 8'd1;
                if (st_route_left == 8'd0)
                    st_phase = rmhp_pkg::PH_PAYLOAD;
                else if (it.last_byte)
                    bad = 1'b1;
            end
            rmhp_pkg::PH_CODE:
            begin
                st_code = st_code | (32'(b) << (8 * st_code_cnt));
                if (st_code_cnt >= rmhp_pkg::CODE_LAST_BYTE)
                begin
                    st_phase = rmhp_pkg::PH_PAYLOAD;
                end
                else
                begin
                    st_code_cnt = st_code_cnt + 2'd1;
                    if (it.last_byte)
                        bad = 1'b1;
                end
            end
            rmhp_pkg::PH_PAYLOAD:
            begin
                if (st_payload_cnt < PAYLOAD_CAP)
                    st_payload_cnt = st_payload_cnt + 16'd1;
            end
            default:
            begin
                role = rmhp_pkg::PH_ERROR;
            end
        endcase

        if (bad)
        begin
            st_error = 1'b1;
            st_phase = rmhp_pkg::PH_ERROR;
        end

        r = '0;
        r.byte_role  = role;
        r.byte_value = b;
        if (it.last_byte)
        begin
            r.is_last   = 1'b1;
            r.status    = st_error;
            r.msg_type  = st_type;
            r.data_kind = st_kind;
            if (!st_error)
            begin
                if (st_type == rmhp_pkg::MT_REQUEST || st_type == rmhp_pkg::MT_RESPONSE)
                    r.msg_id = st_id;
                if (st_type == rmhp_pkg::MT_RESPONSE)
                    r.resp_code = st_code;
                else
                    r.route_len = st_route_total;
                r.payload_len = st_payload_cnt;
            end
            clear_parse_state();
        end
        return r;
    endfunction

    // Gap length for either side: mostly none or short, a few long.
    function automatic int idle_length();
        int r;
        if (full_rate)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // Compare one result item with the oldest prediction.
    function automatic void compare_result(rmhp_pkg::out_item_t got);
        rmhp_pkg::out_item_t want;
        if (expected_results.size() == 0)
        begin
            $error("result item with no prediction pending: %h", got);
            fail_count++;
            return;
        end
        want = expected_results.pop_front();
        check_field("byte_role", want.byte_role, got.byte_role);
        check_field("byte_value", want.byte_value, got.byte_value);
        check_field("is_last", want.is_last, got.is_last);
        check_field("status", want.status, got.status);
        check_field("msg_type", want.msg_type, got.msg_type);
        check_field("data_kind", want.data_kind, got.data_kind);
        check_field("msg_id", want.msg_id, got.msg_id);
        check_field("resp_code", want.resp_code, got.resp_code);
        check_field("route_len", want.route_len, got.route_len);
        check_field("payload_len", want.payload_len, got.payload_len);
    endfunction

    // Result side: check each accepted item, then pick the next ready value.
    initial
    begin : result_monitor
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
                compare_result(result_item);
            if (full_rate)
            begin
                stall_left = 0;
                result_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = idle_length();
            end
        end
    end

    // Offer one byte, wait for it to be taken and record its prediction.
    task automatic send_byte(input logic [7:0] value, input logic last);
        int                 gap;
        rmhp_pkg::in_item_t it;
        gap = idle_length();
        it.data_byte = value;
        it.last_byte = last;
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (!byte_ready);
        expected_results.push_back(parse_byte(it));
    endtask

    // Send the bytes in msg_bytes as one message, marking the final one.
    task automatic send_message();
        int i;
        for (i = 0; i < msg_bytes.size(); i++)
            send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    endtask

    // Fill msg_bytes with a message of the given shape and random content.
    function automatic void build_message(msg_shape_t shape);
        int         n_id;
        int         n_route;
        int         n_payload;
        int         cut;
        int         i;
        logic [2:0] mtype;
        logic [7:0] b;
        msg_bytes.delete();
        if (shape == MSG_NOISE)
        begin
            repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
            return;
        end

        if (shape == MSG_BAD_TYPE)
            mtype = 3'($urandom_range(4, 7));
        else if (shape == MSG_LONG_ID)
            mtype = ($urandom_range(0, 1) != 0) ? rmhp_pkg::MT_REQUEST
                                                 : rmhp_pkg::MT_RESPONSE;
        else
            mtype = 3'($urandom_range(0, 3));
        b = 8'($urandom);
        b[3:1] = mtype;
        msg_bytes.push_back(b);

        // Varint id: every group but the final one has its continuation bit set.
        if (mtype == rmhp_pkg::MT_REQUEST || mtype == rmhp_pkg::MT_RESPONSE)
        begin
            if (shape == MSG_LONG_ID)
                n_id = $urandom_range(11, 13);
            else if ($urandom_range(0, 3) == 0)
                n_id = $urandom_range(4, 10);
            else
                n_id = $urandom_range(1, 3);
            for (i = 0; i < n_id; i++)
            begin
                b = 8'($urandom);
                b[7] = (i < n_id - 1);
                msg_bytes.push_back(b);
            end
        end

        if (mtype == rmhp_pkg::MT_RESPONSE)
        begin
            repeat (4) msg_bytes.push_back(8'($urandom));
        end
        else if (mtype <= rmhp_pkg::MT_PUSH)
        begin
            n_route = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(0, 6);
            msg_bytes.push_back(8'(n_route));
            repeat (n_route) msg_bytes.push_back(8'($urandom));
        end

        n_payload = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12);
        repeat (n_payload) msg_bytes.push_back(8'($urandom));

        if (shape == MSG_TRUNCATED && msg_bytes.size() > 1)
        begin
            cut = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > cut)
                void'(msg_bytes.pop_back());
        end
    endfunction

    // Well-formed messages of every type at the extremes of their fields.
    task automatic test_wellformed_messages();
        msg_bytes = '{8'h00, 8'h7f, 8'h00, 8'hff};
        send_message();
        // Ten-byte id of all ones; the message ends on the last route byte.
        msg_bytes = '{8'hf1, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                      8'hff, 8'hff, 8'h01, 8'h02, 8'h5a, 8'ha5};
        send_message();
        // A zero route length may end the message.
        msg_bytes = '{8'h02, 8'h00};
        send_message();
        // The fourth code byte ends the message with the most negative code.
        msg_bytes = '{8'h34, 8'h05, 8'h00, 8'h00, 8'h00, 8'h80};
        send_message();
        msg_bytes = '{8'h04, 8'h00, 8'hff, 8'hff, 8'hff, 8'h7f, 8'h00};
        send_message();
        msg_bytes = '{8'h86, 8'h01, 8'hab, 8'h55, 8'haa};
        send_message();
    endtask

    // Each kind of malformed message.
    task automatic test_malformed_messages();
        // Bad type, then bytes ignored up to the end.
        msg_bytes = '{8'h08, 8'h00, 8'h01};
        send_message();
        msg_bytes = '{8'h7e};
        send_message();
        // Flag byte alone.
        msg_bytes = '{8'h02};
        send_message();
        // Message ends inside the id, unterminated and terminated.
        msg_bytes = '{8'h00, 8'h85};
        send_message();
        msg_bytes = '{8'h04, 8'h05};
        send_message();
        // Tenth id byte still has its continuation bit set.
        msg_bytes = '{8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
                      8'h80, 8'h80, 8'h80, 8'h01, 8'h02};
        send_message();
        // Route bytes still owed at the end.
        msg_bytes = '{8'h02, 8'h03, 8'h11};
        send_message();
        msg_bytes = '{8'h06, 8'h05};
        send_message();
        // Code cut short.
        msg_bytes = '{8'h04, 8'h01, 8'h22, 8'h33};
        send_message();
    endtask

    // A long payload sent back to back with no stalls on either side.
    task automatic test_long_payload();
        full_rate = 1'b1;
        msg_bytes.delete();
        msg_bytes.push_back(8'h12);
        msg_bytes.push_back(8'h00);
        repeat (LONG_PAYLOAD_BYTES) msg_bytes.push_back(8'($urandom));
        send_message();
        full_rate = 1'b0;
    endtask

    // Mostly well-formed messages with random content, plus broken ones and noise.
    task automatic test_random_traffic();
        int         sent;
        int         r;
        msg_shape_t shape;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            full_rate = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 60)
                shape = MSG_GOOD;
            else if (r < 75)
                shape = MSG_TRUNCATED;
            else if (r < 83)
                shape = MSG_LONG_ID;
            else if (r < 90)
                shape = MSG_BAD_TYPE;
            else
                shape = MSG_NOISE;
            build_message(shape);
            sent += msg_bytes.size();
            send_message();
        end
        full_rate = 1'b0;
    endtask

    initial
    begin
        clear_parse_state();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_wellformed_messages();
        test_malformed_messages();
        test_long_payload();
        test_random_traffic();

        // Drain the outstanding results, then allow for stray extra items.
        byte_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #4_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
